FILE: sv/cbpg_pkg.sv
// Shared types, constants and the bar colour table of the colour bar generator.
// No dependencies; the size register and the top level import it.
package cbpg_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;
  localparam int RESET_WIDTH        = 640;
  localparam int RESET_HEIGHT       = 480;

  localparam int BAR_COUNT   = 7;
  localparam int BAR_IDX_W   = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int SIZE_REG_W  = 13;
  localparam int MODE_W      = 2;
  localparam int COMP_W      = 8;

  localparam logic [BAR_IDX_W-1:0] BAR_BLACK = BAR_IDX_W'(BAR_COUNT);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MODE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SOLID_RED    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SOLID_GREEN  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SOLID_BLUE   = 3'd5;

  // pattern modes; the unused code behaves as solid
  localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOLID      = 2'd2;

  localparam logic [COMP_W-1:0] RESET_SOLID_RED   = 8'd255;
  localparam logic [COMP_W-1:0] RESET_SOLID_GREEN = 8'd0;
  localparam logic [COMP_W-1:0] RESET_SOLID_BLUE  = 8'd0;

  typedef struct packed {
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } rgb_t;

  // red, orange, yellow, green, cyan, blue, violet; past the last bar is black
  function automatic rgb_t bar_colour(input logic [BAR_IDX_W-1:0] idx);
    rgb_t c;
    case (idx)
      3'd0:    c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      3'd1:    c = '{r: 8'd255, g: 8'd165, b: 8'd0};
      3'd2:    c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      3'd3:    c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      3'd4:    c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      3'd5:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      3'd6:    c = '{r: 8'd139, g: 8'd0,   b: 8'd255};
      default: c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
    endcase
    return c;
  endfunction

endpackage

FILE: sv/color_bar_pattern_generator.sv
// Colour bar test pattern generator, top level: raster counters, bar tracking,
// output register and configuration registers. Depends on cbpg_pkg, cbpg_size_reg.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------------
//  input    | in        | in_valid / in_stall    | restart
//  output   | out       | out_valid / out_stall  | red green blue end_of_line end_of_frame
//  config   | in        | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// One pixel per cycle while the output is not stalled; each transfer in gives its pixel in the
// output register in the next cycle, set by the single counter update path.
// rst is synchronous: counters to pixel zero, registers to their defaults.
// in_stall rises only while a pixel sits in the output register and out_stall is high.
// cfg_ready is always high; a size write takes effect on the next transfer.
module color_bar_pattern_generator
  import cbpg_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COMP_W-1:0]      red,
  output logic [COMP_W-1:0]      green,
  output logic [COMP_W-1:0]      blue,
  output logic                   end_of_line,
  output logic                   end_of_frame,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WSW = $clog2(MAX_WIDTH + 1);
  localparam int HSW = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = (WSW > HSW) ? WSW : HSW;
  localparam int CXW = ((CW > WSW) ? CW : WSW) + 1;
  localparam int RXW = ((RW > HSW) ? RW : HSW) + 1;

  logic              accept;
  logic              cfg_wr;

  logic [WSW-1:0]    size_w;
  logic [WSW-1:0]    bar_w;
  logic [HSW-1:0]    size_h;
  logic [HSW-1:0]    bar_h;

  logic [MODE_W-1:0] pattern_mode;
  logic [COMP_W-1:0] solid_red;
  logic [COMP_W-1:0] solid_green;
  logic [COMP_W-1:0] solid_blue;

  logic [CW-1:0]        column_count, column_count_next;
  logic [RW-1:0]        row_count, row_count_next;
  logic [BAR_IDX_W-1:0] bar_index, bar_index_next;
  logic [PW-1:0]        bar_position, bar_position_next;

  logic [CW-1:0]        col_cur;
  logic [RW-1:0]        row_cur;
  logic [BAR_IDX_W-1:0] idx_cur;
  logic [PW-1:0]        pos_cur;
  logic [CXW-1:0]       col_p1;
  logic [RXW-1:0]       row_p1;
  logic [PW:0]          pos_p1;
  logic [PW:0]          bw_sel;
  logic                 eol;
  logic                 eof;
  logic [BAR_IDX_W-1:0] adv_idx;
  logic [PW-1:0]        adv_pos;
  rgb_t                 pix;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  cbpg_size_reg #(
    .MAX_SIZE   (MAX_WIDTH),
    .RESET_SIZE (RESET_WIDTH),
    .SW         (WSW)
  ) u_width (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_wr && cfg_index == REG_FRAME_WIDTH),
    .wr_data   (SIZE_REG_W'(cfg_data)),
    .size      (size_w),
    .bar_width (bar_w)
  );

  cbpg_size_reg #(
    .MAX_SIZE   (MAX_HEIGHT),
    .RESET_SIZE (RESET_HEIGHT),
    .SW         (HSW)
  ) u_height (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_wr && cfg_index == REG_FRAME_HEIGHT),
    .wr_data   (SIZE_REG_W'(cfg_data)),
    .size      (size_h),
    .bar_width (bar_h)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= MODE_VERTICAL;
      solid_red    <= RESET_SOLID_RED;
      solid_green  <= RESET_SOLID_GREEN;
      solid_blue   <= RESET_SOLID_BLUE;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_PATTERN_MODE: pattern_mode <= cfg_data[MODE_W-1:0];
        REG_SOLID_RED:    solid_red    <= cfg_data[COMP_W-1:0];
        REG_SOLID_GREEN:  solid_green  <= cfg_data[COMP_W-1:0];
        REG_SOLID_BLUE:   solid_blue   <= cfg_data[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // restart zeroes the counters ahead of this pixel
    col_cur = restart ? '0 : column_count;
    row_cur = restart ? '0 : row_count;
    idx_cur = restart ? '0 : bar_index;
    pos_cur = restart ? '0 : bar_position;

    col_p1 = CXW'(col_cur) + CXW'(1);
    row_p1 = RXW'(row_cur) + RXW'(1);
    eol    = col_p1 >= CXW'(size_w);
    eof    = eol && (row_p1 >= RXW'(size_h));

    bw_sel = (pattern_mode == MODE_HORIZONTAL) ? (PW + 1)'(bar_h) : (PW + 1)'(bar_w);
    pos_p1 = (PW + 1)'(pos_cur) + (PW + 1)'(1);
    if (pos_p1 >= bw_sel) begin
      adv_pos = '0;
      adv_idx = (idx_cur < BAR_BLACK) ? idx_cur + BAR_IDX_W'(1) : idx_cur;
    end else begin
      adv_pos = pos_p1[PW-1:0];
      adv_idx = idx_cur;
    end

    case (pattern_mode)
      MODE_VERTICAL, MODE_HORIZONTAL: pix = bar_colour(idx_cur);
      default: pix = '{r: solid_red, g: solid_green, b: solid_blue};
    endcase

    bar_index_next    = idx_cur;
    bar_position_next = pos_cur;
    case (pattern_mode)
      MODE_VERTICAL: begin
        if (eol) begin
          bar_index_next    = '0;
          bar_position_next = '0;
        end else begin
          bar_index_next    = adv_idx;
          bar_position_next = adv_pos;
        end
      end
      MODE_HORIZONTAL: begin
        if (eof) begin
          bar_index_next    = '0;
          bar_position_next = '0;
        end else if (eol) begin
          bar_index_next    = adv_idx;
          bar_position_next = adv_pos;
        end
      end
      default: begin
        if (eof) begin
          bar_index_next    = '0;
          bar_position_next = '0;
        end
      end
    endcase

    if (eol) begin
      column_count_next = '0;
      row_count_next    = eof ? '0 : row_p1[RW-1:0];
    end else begin
      column_count_next = col_p1[CW-1:0];
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      bar_index    <= '0;
      bar_position <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      bar_index    <= bar_index_next;
      bar_position <= bar_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red          <= pix.r;
      green        <= pix.g;
      blue         <= pix.b;
      end_of_line  <= eol;
      end_of_frame <= eof;
    end
  end

  a_eof_on_eol : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!end_of_frame || end_of_line))
    else $error("end of frame without end of line");

  a_accept_gives_pixel : assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("transfer in did not load the output register");

  a_line_wrap : assert property (@(posedge clk) disable iff (rst)
    (accept && eol) |=> (column_count == '0))
    else $error("column counter did not wrap at end of line");

  a_restart_col : assert property (@(posedge clk) disable iff (rst)
    (accept && restart && !eol) |=> (column_count == CW'(1)))
    else $error("restart did not begin the line at column zero");

endmodule

FILE: sv/cbpg_size_reg.sv
// Frame size register: clamps the written size to 1..MAX_SIZE and keeps the
// bar width max(1, size/7) alongside it. Depends on cbpg_pkg.
module cbpg_size_reg
  import cbpg_pkg::*;
#(
  parameter int MAX_SIZE   = DEFAULT_MAX_WIDTH,
  parameter int RESET_SIZE = RESET_WIDTH,
  parameter int SW         = $clog2(MAX_SIZE + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [SIZE_REG_W-1:0] wr_data,
  output logic [SW-1:0]         size,
  output logic [SW-1:0]         bar_width
);

  localparam int XW = (SW > SIZE_REG_W) ? SW : SIZE_REG_W;
  // reciprocal of 7, exact for every value below 2**SW
  localparam int K = SW + 3;
  localparam logic [K-1:0] MULT = K'(((2 ** K) + BAR_COUNT - 1) / BAR_COUNT);

  localparam int RST_CLAMP = (RESET_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_SIZE;
  localparam int RST_BAR   = (RST_CLAMP / BAR_COUNT == 0) ? 1 : RST_CLAMP / BAR_COUNT;

  logic [XW-1:0]   wd_ext;
  logic [SW-1:0]   clamped;
  logic [SW+K-1:0] prod;
  logic [SW-1:0]   quot;
  logic [SW-1:0]   bar_width_next;

  always_comb begin
    wd_ext = XW'(wr_data);
    if (wd_ext == '0) begin
      clamped = SW'(1);
    end else if (wd_ext > XW'(MAX_SIZE)) begin
      clamped = SW'(MAX_SIZE);
    end else begin
      clamped = wd_ext[SW-1:0];
    end
    prod           = (SW + K)'(clamped) * (SW + K)'(MULT);
    quot           = prod[SW+K-1:K];
    bar_width_next = (quot == '0) ? SW'(1) : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= SW'(RST_CLAMP);
      bar_width <= SW'(RST_BAR);
    end else if (wr_en) begin
      size      <= clamped;
      bar_width <= bar_width_next;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for color_bar_pattern_generator: directed rows, then random frames
// under random idling, with every pixel checked against an in-bench raster model or a typed expectation.
// Depends on cbpg_pkg and the generator RTL only.
module tb
  import cbpg_pkg::*;
();

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [MODE_W-1:0] MODE_SOLID_ALIAS = 2'd3;
  localparam int RANDOM_PIXELS = 900;
  localparam int WIDE_PIXELS   = 150 + 10;
  localparam int LONG_HOLD     = 80;
  localparam int DRAIN_LIMIT   = 2000;

  localparam logic [23:0] BAR_RGB [0:6] = '{
    24'hFF0000, 24'hFFA500, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'h8B00FF
  };

  typedef struct packed {
    rgb_t colour;
    logic eol;
    logic eof;
  } pixel_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0]   data;
    logic                    rs;
    pixel_t                  px;
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   restart;
  logic                   out_valid;
  logic                   out_stall;
  logic [COMP_W-1:0]      red;
  logic [COMP_W-1:0]      green;
  logic [COMP_W-1:0]      blue;
  logic                   end_of_line;
  logic                   end_of_frame;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  color_bar_pattern_generator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // raster model state and register copies
  logic [SIZE_REG_W-1:0] mdl_width, mdl_height;
  logic [MODE_W-1:0]     mdl_mode;
  logic [COMP_W-1:0]     mdl_red, mdl_green, mdl_blue;
  logic [11:0]           col, row, bar_pos;
  logic [BAR_IDX_W-1:0]  bar;

  pixel_t expected_pixels [$];
  int unsigned errors, pixels_checked, eol_seen, eof_seen, reg_writes;
  int unsigned holds_asked, holds_done;

  function automatic logic [SIZE_REG_W-1:0] clamp_dim(input logic [SIZE_REG_W-1:0] v,
                                                      input int unsigned lim);
    if (v == '0) return SIZE_REG_W'(1);
    if (v > lim) return SIZE_REG_W'(lim);
    return v;
  endfunction

  function automatic void step_bar(input logic [SIZE_REG_W-1:0] span);
    logic [SIZE_REG_W-1:0] bw;
    bw = SIZE_REG_W'(span / BAR_COUNT);
    if (bw == '0) bw = SIZE_REG_W'(1);
    if (bar_pos + 1 >= bw) begin
      bar_pos = '0;
      if (bar < BAR_COUNT) bar = bar + 1'b1;
    end else begin
      bar_pos = bar_pos + 1'b1;
    end
  endfunction

  function automatic void clear_bars();
    bar = '0;
    bar_pos = '0;
  endfunction

  // one pixel of the raster, advancing the counters as the generator does
  function automatic pixel_t paint_pixel(input logic rs);
    logic [SIZE_REG_W-1:0] w, h;
    pixel_t px;
    w = clamp_dim(mdl_width, DEFAULT_MAX_WIDTH);
    h = clamp_dim(mdl_height, DEFAULT_MAX_HEIGHT);
    if (rs) begin
      col = '0;
      row = '0;
      clear_bars();
    end
    px.eol = (col + 1 >= w);
    px.eof = px.eol && (row + 1 >= h);
    if (mdl_mode == MODE_VERTICAL || mdl_mode == MODE_HORIZONTAL) begin
      if (bar < BAR_COUNT) px.colour = BAR_RGB[bar];
      else px.colour = '0;
    end else begin
      px.colour = '{r: mdl_red, g: mdl_green, b: mdl_blue};
    end
    case (mdl_mode)
      MODE_HORIZONTAL: begin
        if (px.eof) clear_bars();
        else if (px.eol) step_bar(h);
      end
      MODE_VERTICAL: begin
        if (px.eol) clear_bars();
        else step_bar(w);
      end
      default: begin
        if (px.eof) clear_bars();
      end
    endcase
    if (px.eol) begin
      col = '0;
      row = px.eof ? 12'd0 : row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    return px;
  endfunction

  function automatic void model_reset();
    mdl_width = SIZE_REG_W'(RESET_WIDTH);
    mdl_height = SIZE_REG_W'(RESET_HEIGHT);
    mdl_mode = MODE_VERTICAL;
    mdl_red = RESET_SOLID_RED;
    mdl_green = RESET_SOLID_GREEN;
    mdl_blue = RESET_SOLID_BLUE;
    col = '0;
    row = '0;
    clear_bars();
  endfunction

  function automatic plan_row_t wr_row(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    return '{kind: ROW_WRITE, idx: idx, data: data, rs: 1'b0, px: '0};
  endfunction

  function automatic plan_row_t px_row(input logic rs);
    return '{kind: ROW_PIXEL, idx: '0, data: '0, rs: rs, px: '0};
  endfunction

  function automatic plan_row_t typed_row(input logic rs, input logic [23:0] rgb,
                                          input logic eol, input logic eof);
    pixel_t px;
    px.colour = rgb;
    px.eol = eol;
    px.eof = eof;
    return '{kind: ROW_TYPED, idx: '0, data: '0, rs: rs, px: px};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: stall segments of varying density, plus long hold-offs on request
  initial begin
    int unsigned seg_left, stall_pct;
    seg_left = 0;
    stall_pct = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
        out_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 200);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // output checker: each pixel transfer against the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel transfer with nothing expected");
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (end_of_line) eol_seen++;
        if (end_of_frame) eof_seen++;
        if (red !== want.colour.r) begin
          $error("red: expected %0d, got %0d", want.colour.r, red);
          errors++;
        end
        if (green !== want.colour.g) begin
          $error("green: expected %0d, got %0d", want.colour.g, green);
          errors++;
        end
        if (blue !== want.colour.b) begin
          $error("blue: expected %0d, got %0d", want.colour.b, blue);
          errors++;
        end
        if (end_of_line !== want.eol) begin
          $error("end_of_line: expected %0d, got %0d", want.eol, end_of_line);
          errors++;
        end
        if (end_of_frame !== want.eof) begin
          $error("end_of_frame: expected %0d, got %0d", want.eof, end_of_frame);
          errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  mdl_width  = data;
      REG_FRAME_HEIGHT: mdl_height = data;
      REG_PATTERN_MODE: mdl_mode   = data[MODE_W-1:0];
      REG_SOLID_RED:    mdl_red    = data[COMP_W-1:0];
      REG_SOLID_GREEN:  mdl_green  = data[COMP_W-1:0];
      REG_SOLID_BLUE:   mdl_blue   = data[COMP_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // offers one pixel request and holds it until the transfer
  task automatic send_pixel(input logic rs, input logic typed, input pixel_t want);
    pixel_t px;
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    px = paint_pixel(rs);
    expected_pixels.push_back(typed ? want : px);
  endtask

  task automatic run_directed();
    plan_row_t plan [$];
    plan = '{
      typed_row(1'b0, 24'hFF0000, 1'b0, 1'b0),
      typed_row(1'b1, 24'hFF0000, 1'b0, 1'b0),
      px_row(1'b0),
      // zero sizes behave as one: every pixel ends line and frame
      wr_row(REG_FRAME_WIDTH, 13'd0),
      wr_row(REG_FRAME_HEIGHT, 13'd0),
      typed_row(1'b0, 24'hFF0000, 1'b1, 1'b1),
      typed_row(1'b0, 24'hFF0000, 1'b1, 1'b1),
      // one-column bars, three black columns past the violet one
      wr_row(REG_FRAME_WIDTH, 13'd10),
      wr_row(REG_FRAME_HEIGHT, 13'd3),
      wr_row(REG_PATTERN_MODE, 13'(MODE_VERTICAL)),
      px_row(1'b0), px_row(1'b0), px_row(1'b0), px_row(1'b0), px_row(1'b0),
      px_row(1'b0), px_row(1'b0), px_row(1'b0), px_row(1'b0), px_row(1'b0),
      // upper data bits must be dropped by the colour registers
      wr_row(REG_SOLID_RED, 13'h1F00),
      wr_row(REG_SOLID_GREEN, 13'h00FF),
      wr_row(REG_SOLID_BLUE, 13'h0A80),
      wr_row(REG_PATTERN_MODE, 13'(MODE_SOLID)),
      typed_row(1'b1, 24'h00FF80, 1'b0, 1'b0),
      wr_row(REG_PATTERN_MODE, 13'(MODE_SOLID_ALIAS)),
      typed_row(1'b0, 24'h00FF80, 1'b0, 1'b0),
      wr_row(REG_SPARE_LO, 13'h1FFF),
      wr_row(REG_SPARE_HI, 13'h0000),
      typed_row(1'b0, 24'h00FF80, 1'b0, 1'b0),
      // mode change and width shrink mid-frame
      wr_row(REG_PATTERN_MODE, 13'(MODE_HORIZONTAL)),
      wr_row(REG_FRAME_WIDTH, 13'd2),
      wr_row(REG_FRAME_HEIGHT, 13'd14),
      px_row(1'b0), px_row(1'b0), px_row(1'b0), px_row(1'b0), px_row(1'b0),
      wr_row(REG_FRAME_WIDTH, 13'h1FFF),
      wr_row(REG_FRAME_HEIGHT, 13'd4096),
      px_row(1'b1), px_row(1'b0)
    };
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        if (k > 0 && plan[k-1].kind != ROW_WRITE) in_valid <= 1'b0;
        wait_idle();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_pixel(plan[k].rs, plan[k].kind == ROW_TYPED, plan[k].px);
      end
    end
    in_valid <= 1'b0;
  endtask

  function automatic logic [SIZE_REG_W-1:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return SIZE_REG_W'($urandom_range(4096, 8191));
    if (pick < 5) return SIZE_REG_W'($urandom_range(25, 300));
    return SIZE_REG_W'($urandom_range(1, 24));
  endfunction

  // n pixels; restart mostly at the start, bursts and gaps when gappy
  task automatic run_phase(input int unsigned n, input bit gappy);
    int unsigned burst_left;
    logic rs;
    burst_left = $urandom_range(1, 30);
    for (int unsigned i = 0; i < n; i++) begin
      rs = (i == 0) ? logic'($urandom_range(0, 1)) : ($urandom_range(0, 49) == 0);
      send_pixel(rs, 1'b0, '0);
      if (gappy && i + 1 < n) begin
        burst_left--;
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = $urandom_range(1, 30);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sent, phase, n, drain;
    errors = 0;
    pixels_checked = 0;
    eol_seen = 0;
    eof_seen = 0;
    reg_writes = 0;
    holds_asked = 0;
    holds_done = 0;
    model_reset();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    restart   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      wait_idle();
      if ($urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, random_dim());
      if ($urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, random_dim());
      if ($urandom_range(0, 1)) write_reg(REG_PATTERN_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_SOLID_RED, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 2) == 0) write_reg(REG_SOLID_GREEN, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 2) == 0) write_reg(REG_SOLID_BLUE, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
      n = $urandom_range(20, 120);
      // long receiver hold-off while requests keep coming
      if (phase == 2 || phase == 7) begin
        holds_asked++;
        run_phase(n, 1'b0);
      end else begin
        run_phase(n, $urandom_range(0, 3) != 0);
      end
      sent += n;
      phase++;
    end

    // one full line of a wide frame, so the last bar and the black columns show
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 13'd150);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_PATTERN_MODE, 13'(MODE_VERTICAL));
    send_pixel(1'b1, 1'b0, '0);
    run_phase(WIDE_PIXELS - 1, 1'b0);

    drain = 0;
    while (expected_pixels.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", expected_pixels.size());
      errors++;
    end

    $display("Checked %0d pixels over %0d random phases and %0d register writes,",
             pixels_checked, phase, reg_writes);
    $display("with %0d line ends and %0d frame ends among them.", eol_seen, eof_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: color_bar_pattern_generator.f
sv/cbpg_pkg.sv
sv/cbpg_size_reg.sv
sv/color_bar_pattern_generator.sv
tb/tb.sv
